// File: rtl/core/bmhq_pkg.sv
// bmhq_pkg: shared types and constants of the binary min-heap queue.
// Used by bmhq_cmp and binary_min_heap_queue; depends on nothing.
`default_nettype none

package bmhq_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int VALUE_W      = 32;
    localparam int STATUS_W     = 2;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [STATUS_W-1:0]       t_status;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

// File: rtl/core/bmhq_cmp.sv
// bmhq_cmp: the shared signed less-than unit of the heap sequencer.
// Depends on bmhq_pkg for the value type.
`default_nettype none

module bmhq_cmp (
    input  wire bmhq_pkg::t_value i_a,
    input  wire bmhq_pkg::t_value i_b,
    output logic                  o_less
);

    // signed compare on two's complement words
    assign o_less = (i_a < i_b);

endmodule

`default_nettype wire

// File: rtl/core/binary_min_heap_queue.sv
// binary_min_heap_queue: top level, sequencer and heap storage.
// Depends on bmhq_pkg and bmhq_cmp.
`default_nettype none

// Priority queue of signed 32-bit words held as a binary min-heap of CAPACITY
// entries. Pulse start while busy is low to hand in one request: i_operation 0
// inserts i_value, 1 removes the minimum. Exactly one result word comes back,
// shown for a single cycle with o_valid high; the receiver cannot stall it, so
// capture it in that cycle. o_status is ok, full (insert dropped) or empty
// (remove refused); o_count_after is the element count after the request and
// o_removed_value the minimum taken (zero otherwise). A refused request
// answers in the next cycle. An insert keeps busy high while the word climbs
// toward the root, at most log2(CAPACITY) levels; a remove keeps it high
// while the word sinks toward the leaves, until a leaf or a failed compare
// stops it. The result is shown in the same cycle that busy drops. The cost
// per level is set by the single read port of the heap memory, whose read
// data is registered, and by the one compare unit that the sequencer shares
// between all comparisons. A new request may be started in the same cycle
// the result is shown. The heap memory is not cleared at reset; only slots
// below the count are read.
module binary_min_heap_queue #(
    parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF,
    localparam int IW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    start,
    output logic                   busy,
    input  wire                    i_operation,
    input  wire bmhq_pkg::t_value  i_value,
    output logic                   o_valid,
    output bmhq_pkg::t_value       o_removed_value,
    output bmhq_pkg::t_status      o_status,
    output logic [CW-1:0]          o_count_after
);

    localparam int XW = IW + 2;   // wide enough for child indexes and counts

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_UP_CHK  = 4'd1;
    localparam logic [3:0] S_UP_CMP  = 4'd2;
    localparam logic [3:0] S_RM_ROOT = 4'd3;
    localparam logic [3:0] S_RM_LAST = 4'd4;
    localparam logic [3:0] S_DN_CHK  = 4'd5;
    localparam logic [3:0] S_DN_LEFT = 4'd6;
    localparam logic [3:0] S_DN_RGT  = 4'd7;
    localparam logic [3:0] S_DN_CMP  = 4'd8;

    logic [3:0]          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [IW-1:0]       r_pos, n_pos;
    logic [IW-1:0]       r_child, n_child;
    bmhq_pkg::t_value    r_item, n_item;
    bmhq_pkg::t_value    r_best, n_best;
    bmhq_pkg::t_value    r_removed, n_removed;
    bmhq_pkg::t_status   r_status, n_status;
    logic                r_valid, n_valid;

    // heap memory: one write port, one registered read port
    bmhq_pkg::t_value    mem [CAPACITY];
    bmhq_pkg::t_value    r_rd_data;
    logic [IW-1:0]       rd_addr;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    bmhq_pkg::t_value    wr_data;

    // shared compare unit
    bmhq_pkg::t_value    cmp_a, cmp_b;
    logic                cmp_less;

    logic                accept;
    logic [IW-1:0]       parent;
    logic [XW-1:0]       child_x;
    logic [XW-1:0]       size_x;

    bmhq_cmp u_cmp (
        .i_a    (cmp_a),
        .i_b    (cmp_b),
        .o_less (cmp_less)
    );

    assign accept  = start && !busy;
    assign busy    = (r_state != S_IDLE);
    assign parent  = IW'((r_pos - 1'b1) >> 1);
    assign child_x = {1'b0, r_pos, 1'b1};
    assign size_x  = XW'(r_count);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_child   = r_child;
        n_item    = r_item;
        n_best    = r_best;
        n_removed = r_removed;
        n_status  = r_status;
        n_valid   = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = r_pos;
        wr_data   = r_item;
        cmp_a     = r_best;
        cmp_b     = r_item;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_removed = '0;
                    n_status  = bmhq_pkg::ST_OK;
                    if (i_operation == bmhq_pkg::OP_INSERT) begin
                        if (r_count >= CW'(CAPACITY)) begin
                            // full: drop the word, answer at once
                            n_status = bmhq_pkg::ST_FULL;
                            n_valid  = 1'b1;
                        end else begin
                            n_item  = i_value;
                            n_pos   = IW'(r_count);
                            n_count = r_count + 1'b1;
                            n_state = S_UP_CHK;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = bmhq_pkg::ST_EMPTY;
                            n_valid  = 1'b1;
                        end else begin
                            rd_addr = '0;
                            n_state = S_RM_ROOT;
                        end
                    end
                end
            end
            S_UP_CHK: begin
                if (r_pos == '0) begin
                    wr_en   = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    rd_addr = parent;
                    n_child = parent;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                cmp_a = r_rd_data;
                cmp_b = r_item;
                wr_en = 1'b1;
                if (cmp_less) begin
                    // parent strictly smaller: settle here
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    // move the parent down and climb
                    wr_data = r_rd_data;
                    n_pos   = r_child;
                    n_state = S_UP_CHK;
                end
            end
            S_RM_ROOT: begin
                n_removed = r_rd_data;
                rd_addr   = IW'(r_count - 1'b1);
                n_count   = r_count - 1'b1;
                n_state   = S_RM_LAST;
            end
            S_RM_LAST: begin
                n_item = r_rd_data;
                n_pos  = '0;
                if (r_count == '0) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_DN_CHK;
                end
            end
            S_DN_CHK: begin
                if (child_x >= size_x) begin
                    wr_en   = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    rd_addr = IW'(child_x);
                    n_state = S_DN_LEFT;
                end
            end
            S_DN_LEFT: begin
                n_best  = r_rd_data;
                n_child = IW'(child_x);
                if ((child_x + 1'b1) < size_x) begin
                    rd_addr = IW'(child_x + 1'b1);
                    n_state = S_DN_RGT;
                end else begin
                    n_state = S_DN_CMP;
                end
            end
            S_DN_RGT: begin
                // take the right child only if strictly smaller
                cmp_a = r_rd_data;
                cmp_b = r_best;
                if (cmp_less) begin
                    n_best  = r_rd_data;
                    n_child = r_child + 1'b1;
                end
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                cmp_a = r_best;
                cmp_b = r_item;
                wr_en = 1'b1;
                if (cmp_less) begin
                    // lift the child and sink one level
                    wr_data = r_best;
                    n_pos   = r_child;
                    n_state = S_DN_CHK;
                end else begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_pos     <= n_pos;
        r_child   <= n_child;
        r_item    <= n_item;
        r_best    <= n_best;
        r_removed <= n_removed;
        r_status  <= n_status;
    end

    assign o_valid         = r_valid;
    assign o_removed_value = r_removed;
    assign o_status        = r_status;
    assign o_count_after   = r_count;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_strobe_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while sequencer busy");

    a_full_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == bmhq_pkg::ST_FULL) |-> (o_count_after == CW'(CAPACITY)))
        else $error("full status with heap not full");

    a_empty_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == bmhq_pkg::ST_EMPTY)
            |-> (o_count_after == '0 && o_removed_value == '0))
        else $error("empty status with stale count or value");

    a_accept_moves : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted request neither started nor answered");

endmodule

`default_nettype wire

// File: sim/binary_min_heap_queue_test.sv
// binary_min_heap_queue_test: self-checking bench for the binary min-heap queue.
// Depends on bmhq_pkg and binary_min_heap_queue; predicts every result word
// with its own heap copy and checks the design word by word.
`default_nettype none

module binary_min_heap_queue_test;

    localparam int   CAP          = bmhq_pkg::CAPACITY_DEF;
    localparam int   CNT_W        = $clog2(CAP + 1);
    localparam int   TOTAL_WORDS  = 1550;
    // IDLE_LIMIT stays well above the slowest remove and the longest sender
    // gap.
    localparam int   IDLE_LIMIT   = 2000;
    localparam int   TAIL_CYCLES  = 40;

    // One pending request: the gap to idle before it, and whether to hold it
    // until every outstanding result word has come back.
    typedef struct {
        logic             op;
        bmhq_pkg::t_value value;
        int               gap;
        bit               drain;
    } t_heap_request;

    typedef struct {
        bmhq_pkg::t_value  removed;
        bmhq_pkg::t_status status;
        logic [CNT_W-1:0]  count;
    } t_heap_answer;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              i_operation = 1'b0;
    bmhq_pkg::t_value  i_value     = '0;
    logic              busy;
    logic              o_valid;
    bmhq_pkg::t_value  o_removed_value;
    bmhq_pkg::t_status o_status;
    logic [CNT_W-1:0]  o_count_after;

    t_heap_request pending_words[$];
    t_heap_answer  expected_answers[$];
    int            n_issued    = 0;
    int            n_done      = 0;
    int            n_errors    = 0;
    int            idle_cycles = 0;
    bit            run_done    = 1'b0;

    // Shadow copy of the heap, kept in step with every accepted request.
    bmhq_pkg::t_value heap_mem [CAP];
    int               heap_cnt = 0;

    binary_min_heap_queue u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .o_removed_value (o_removed_value),
        .o_status        (o_status),
        .o_count_after   (o_count_after)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Apply one request to the shadow heap and return the answer it must give.
    // Sift-up passes equal values; sift-down takes the right child only when
    // it is strictly smaller, and moves a child up only while it is smaller.
    function automatic t_heap_answer heap_apply(logic op, bmhq_pkg::t_value val);
        t_heap_answer     ans;
        int               pos;
        int               parent;
        int               child;
        bmhq_pkg::t_value item;
        ans.removed = '0;
        ans.status  = bmhq_pkg::ST_OK;
        if (op == bmhq_pkg::OP_INSERT) begin
            if (heap_cnt >= CAP) begin
                ans.status = bmhq_pkg::ST_FULL;
            end else begin
                pos  = heap_cnt;
                item = val;
                while (pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (heap_mem[parent] < item)
                        break;
                    heap_mem[pos] = heap_mem[parent];
                    pos = parent;
                end
                heap_mem[pos] = item;
                heap_cnt++;
            end
        end else if (heap_cnt == 0) begin
            ans.status = bmhq_pkg::ST_EMPTY;
        end else begin
            ans.removed = heap_mem[0];
            heap_cnt--;
            item  = heap_mem[heap_cnt];
            pos   = 0;
            child = 1;
            while (child < heap_cnt) begin
                if (child + 1 < heap_cnt && heap_mem[child + 1] < heap_mem[child])
                    child++;
                if (!(heap_mem[child] < item))
                    break;
                heap_mem[pos] = heap_mem[child];
                pos   = child;
                child = 2 * pos + 1;
            end
            heap_mem[pos] = item;
        end
        ans.count = CNT_W'(heap_cnt);
        return ans;
    endfunction

    // Mix wide random words with a narrow band (to force equal keys) and the
    // edges of the signed range.
    function automatic bmhq_pkg::t_value pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return bmhq_pkg::t_value'($urandom());
            4, 5, 6:    return bmhq_pkg::t_value'(int'($urandom_range(0, 16)) - 8);
            7:          return $urandom_range(0, 1) ? bmhq_pkg::t_value'(32'h7fff_ffff)
                                                    : bmhq_pkg::t_value'(32'h8000_0000);
            8:          return bmhq_pkg::t_value'(32'h7fff_ffff - $urandom_range(0, 3));
            default:    return bmhq_pkg::t_value'(32'h8000_0000 + $urandom_range(0, 3));
        endcase
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_word(logic op, bmhq_pkg::t_value val, int gap, bit drain);
        t_heap_request req;
        req.op    = op;
        req.value = val;
        req.gap   = gap;
        req.drain = drain;
        pending_words.insert(pending_words.size(), req);
    endtask

    task automatic note_mismatch(string what);
        n_errors++;
        if (n_errors <= 10)
            $display("mismatch at result %0d: %s", n_done, what);
    endtask

    // Driver: present the next pending word, hold it until accepted, then
    // advance. start gets exactly one assignment per edge.
    always @(posedge i_clk) begin : drive_words
        logic          nxt_start;
        t_heap_request word;
        nxt_start = start;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
        end else begin
            if (start && !busy) begin
                expected_answers.insert(expected_answers.size(),
                                        heap_apply(i_operation, i_value));
                n_issued++;
                nxt_start = 1'b0;
            end
            if (!nxt_start && pending_words.size() != 0) begin
                // Hold a draining word until every result word is back.
                if (!(pending_words[0].drain && n_issued != n_done)) begin
                    pending_words[0].drain = 1'b0;
                    if (pending_words[0].gap != 0) begin
                        pending_words[0].gap = pending_words[0].gap - 1;
                    end else begin
                        word = pending_words[0];
                        pending_words.delete(0);
                        i_operation <= word.op;
                        i_value     <= word.value;
                        nxt_start   = 1'b1;
                    end
                end
            end
        end
        start <= nxt_start;
    end

    // Monitor: every strobed result word is checked against the oldest
    // expectation; a strobe with nothing outstanding is an error too.
    always @(posedge i_clk) begin : check_words
        t_heap_answer want;
        if (i_rst_n && o_valid) begin
            n_done <= n_done + 1;
            if (expected_answers.size() == 0) begin
                note_mismatch("result word with no request outstanding");
            end else begin
                want = expected_answers[0];
                expected_answers.delete(0);
                if (o_removed_value !== want.removed)
                    note_mismatch($sformatf("removed_value exp %0d got %0d",
                                            want.removed, o_removed_value));
                if (o_status !== want.status)
                    note_mismatch($sformatf("status exp %0d got %0d",
                                            want.status, o_status));
                if (o_count_after !== want.count)
                    note_mismatch($sformatf("count_after exp %0d got %0d",
                                            want.count, o_count_after));
            end
        end
    end

    // Watchdog: drop the run if no word moves in either direction for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || run_done || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("binary_min_heap_queue_test: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int   phase_len;
        int   ins_pct;
        bit   quiet;
        bit   drain;
        bit   first_phase;
        logic op;

        // Directed opening: refused remove on an empty heap, both range
        // extremes, equal keys, bit patterns, removal down to empty.
        queue_word(bmhq_pkg::OP_REMOVE, bmhq_pkg::t_value'(32'h1234_5678), 0, 1'b0);
        queue_word(bmhq_pkg::OP_INSERT, bmhq_pkg::t_value'(32'h7fff_ffff), 0, 1'b0);
        queue_word(bmhq_pkg::OP_INSERT, bmhq_pkg::t_value'(32'h8000_0000), 0, 1'b0);
        queue_word(bmhq_pkg::OP_INSERT, bmhq_pkg::t_value'(0), 1, 1'b0);
        queue_word(bmhq_pkg::OP_INSERT, bmhq_pkg::t_value'(-1), 0, 1'b0);
        queue_word(bmhq_pkg::OP_INSERT, bmhq_pkg::t_value'(1), 0, 1'b0);
        queue_word(bmhq_pkg::OP_INSERT, bmhq_pkg::t_value'(0), 0, 1'b0);
        queue_word(bmhq_pkg::OP_INSERT, bmhq_pkg::t_value'(32'h5555_5555), 2, 1'b0);
        queue_word(bmhq_pkg::OP_INSERT, bmhq_pkg::t_value'(32'haaaa_aaaa), 0, 1'b0);
        repeat (8) queue_word(bmhq_pkg::OP_REMOVE, bmhq_pkg::t_value'($urandom()), 0, 1'b0);
        // A remove on the heap that is already empty again is refused.
        queue_word(bmhq_pkg::OP_REMOVE, bmhq_pkg::t_value'(32'hffff_ffff), 0, 1'b0);
        queue_word(bmhq_pkg::OP_REMOVE, bmhq_pkg::t_value'(0), 0, 1'b0);
        queue_word(bmhq_pkg::OP_INSERT, bmhq_pkg::t_value'(-7), 0, 1'b0);
        queue_word(bmhq_pkg::OP_REMOVE, bmhq_pkg::t_value'(0), 3, 1'b0);
        queue_word(bmhq_pkg::OP_REMOVE, bmhq_pkg::t_value'(0), 0, 1'b0);

        // Random phases: fill bursts that run into a full heap, drain bursts
        // that run it dry, and mixed traffic at a random insert ratio.
        first_phase = 1'b1;
        while (pending_words.size() < TOTAL_WORDS) begin
            quiet = ($urandom_range(0, 3) == 0);
            drain = first_phase || ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 3))
                0: begin
                    ins_pct   = 100;
                    phase_len = $urandom_range(34, 40);
                end
                1: begin
                    ins_pct   = 10;
                    phase_len = $urandom_range(34, 40);
                end
                default: begin
                    ins_pct   = $urandom_range(30, 70);
                    phase_len = $urandom_range(20, 80);
                end
            endcase
            for (int k = 0; k < phase_len; k++) begin
                op = ($urandom_range(0, 99) < ins_pct) ? bmhq_pkg::OP_INSERT
                                                       : bmhq_pkg::OP_REMOVE;
                queue_word(op, pick_value(), pick_gap(quiet), drain && k == 0);
            end
            first_phase = 1'b0;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every word is in and every answer is back, then settle.
        do
            @(negedge i_clk);
        while (pending_words.size() != 0 || start || n_issued != n_done);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        run_done = 1'b1;

        if (n_errors == 0 && expected_answers.size() == 0) begin
            $display("binary_min_heap_queue_test: PASS");
        end else begin
            $display("binary_min_heap_queue_test: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
